>>> src/ftma_pkg.sv
// shared types and constants for the frame-time moving average block
// no dependencies
package ftma_pkg;

	localparam int WINDOW    = 60;
	localparam int SAMPLE_W  = 24;
	localparam int SCALE_W   = 16;
	localparam int RATE_W    = 20;
	localparam int PROD_W    = SAMPLE_W + SCALE_W;
	localparam int FRAC_W    = 8;
	localparam int PTR_W     = $clog2(WINDOW);
	localparam int CNT_W     = $clog2(WINDOW + 1);
	localparam int SUM_W     = SAMPLE_W + $clog2(WINDOW);

	// 2 * 1e6 + mean fits in 25 bits
	localparam int RATE_NUM2   = 2000000;
	localparam int RATE_NUM_W  = 25;
	localparam int DIV_W       = (SUM_W > RATE_NUM_W) ? SUM_W : RATE_NUM_W;
	localparam int DCNT_W      = $clog2(DIV_W);

	localparam logic [SCALE_W-1:0] TIME_SCALE_RST = 16'd256;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_DIV_MEAN,
		ST_LOAD_RATE,
		ST_DIV_RATE,
		ST_DONE
	} ftma_state_t;

endpackage

>>> src/frame_time_moving_average_unit.sv
// frame-time moving average: sliding window sum with a shared serial divider
// depends on ftma_pkg
//
// channel  dir  handshake            payload
// -------  ---  -------------------  ---------------------------------------------
// in       in   in_valid / in_stall  frame_time
// out      out  out_valid / out_stall scaled_delta, mean_delta, mean_rate, window_full
// cfg      in   cfg_wr_en            cfg_wr_data (time_scale)
//
// the result is registered at the output from the done state, after the update, mean
// division, rate load and rate division states; the next input is taken back in idle.
// the time per item is set by the restoring divider that produces one quotient bit a cycle, used
// twice per item (mean, then frame rate). no other item is taken while one is in flight.
// reset clears the sum, fill count, write pointer, state and time_scale (to 1.0);
// the sample memory is not cleared and needs no clearing pass.
// a stalled result waits in the output register; the next input may be taken
// meanwhile, and its result waits in the last state until the register frees.
module frame_time_moving_average_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [ftma_pkg::SCALE_W-1:0]   cfg_wr_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [ftma_pkg::SAMPLE_W-1:0]  frame_time,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [ftma_pkg::SAMPLE_W-1:0]  scaled_delta,
	output logic [ftma_pkg::SAMPLE_W-1:0]  mean_delta,
	output logic [ftma_pkg::RATE_W-1:0]    mean_rate,
	output logic                           window_full
);

	localparam int SAMPLE_W = ftma_pkg::SAMPLE_W;
	localparam int DIV_W    = ftma_pkg::DIV_W;
	localparam int SUM_W    = ftma_pkg::SUM_W;
	localparam int CNT_W    = ftma_pkg::CNT_W;
	localparam int PTR_W    = ftma_pkg::PTR_W;
	localparam int DCNT_W   = ftma_pkg::DCNT_W;
	localparam int PROD_W   = ftma_pkg::PROD_W;
	localparam int FRAC_W   = ftma_pkg::FRAC_W;
	localparam int RATE_W   = ftma_pkg::RATE_W;

	ftma_pkg::ftma_state_t state_q, state_nxt;

	logic [ftma_pkg::SCALE_W-1:0] time_scale_q;
	logic [SAMPLE_W-1:0]          win_mem_q [ftma_pkg::WINDOW];
	logic [SAMPLE_W-1:0]          rd_data_q;
	logic [SAMPLE_W-1:0]          x_q;
	logic [SUM_W-1:0]             sum_q;
	logic [CNT_W-1:0]             fill_q;
	logic [PTR_W-1:0]             wr_ptr_q;
	logic [SAMPLE_W-1:0]          scaled_q;
	logic [SAMPLE_W-1:0]          mean_q;

	logic [DIV_W-1:0]  div_rem_q, div_quo_q, div_den_q;
	logic [DCNT_W-1:0] div_cnt_q;

	logic out_valid_q;
	logic [SAMPLE_W-1:0] out_scaled_q, out_mean_q;
	logic [RATE_W-1:0]   out_rate_q;
	logic                out_full_q;

	// control from the sequencer
	logic             in_xfer, out_xfer;
	logic             upd_en, div_load, div_step, mean_ld, out_ld;
	logic [DIV_W-1:0] div_num, div_den;
	logic             div_last;

	// datapath helpers
	logic             win_full;
	logic [SUM_W-1:0] sum_nxt;
	logic [CNT_W-1:0] fill_nxt;
	logic [PROD_W-1:0] prod;
	logic [DIV_W:0]   trial;
	logic             trial_ge;
	logic [DIV_W:0]   trial_diff;

	assign in_xfer  = in_valid && !in_stall;
	assign out_xfer = out_valid_q && !out_stall;
	assign div_last = (div_cnt_q == '0);

	assign win_full = (fill_q == CNT_W'(ftma_pkg::WINDOW));
	assign sum_nxt  = sum_q + SUM_W'(x_q) - (win_full ? SUM_W'(rd_data_q) : '0);
	assign fill_nxt = win_full ? fill_q : fill_q + CNT_W'(1);
	assign prod     = PROD_W'(x_q) * PROD_W'(time_scale_q);

	assign trial      = {div_rem_q, div_quo_q[DIV_W-1]};
	assign trial_diff = trial - {1'b0, div_den_q};
	assign trial_ge   = (trial >= {1'b0, div_den_q});

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ftma_pkg::ST_IDLE:      if (in_xfer) state_nxt = ftma_pkg::ST_UPDATE;
			ftma_pkg::ST_UPDATE:    state_nxt = ftma_pkg::ST_DIV_MEAN;
			ftma_pkg::ST_DIV_MEAN:  if (div_last) state_nxt = ftma_pkg::ST_LOAD_RATE;
			ftma_pkg::ST_LOAD_RATE: state_nxt = ftma_pkg::ST_DIV_RATE;
			ftma_pkg::ST_DIV_RATE:  if (div_last) state_nxt = ftma_pkg::ST_DONE;
			ftma_pkg::ST_DONE:      if (!out_valid_q || !out_stall) state_nxt = ftma_pkg::ST_IDLE;
			default:                state_nxt = ftma_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall = 1'b1;
		upd_en   = 1'b0;
		div_load = 1'b0;
		div_step = 1'b0;
		mean_ld  = 1'b0;
		out_ld   = 1'b0;
		div_num  = '0;
		div_den  = '0;
		case (state_q)
			ftma_pkg::ST_IDLE: begin
				in_stall = 1'b0;
			end
			ftma_pkg::ST_UPDATE: begin
				upd_en   = 1'b1;
				div_load = 1'b1;
				div_num  = DIV_W'(sum_nxt);
				div_den  = DIV_W'(fill_nxt);
			end
			ftma_pkg::ST_DIV_MEAN: begin
				div_step = 1'b1;
			end
			ftma_pkg::ST_LOAD_RATE: begin
				// rounded 1e6 / mean as (2e6 + mean) / (2 * mean)
				mean_ld  = 1'b1;
				div_load = 1'b1;
				div_num  = DIV_W'(ftma_pkg::RATE_NUM2) + DIV_W'(div_quo_q[SAMPLE_W-1:0]);
				div_den  = DIV_W'({div_quo_q[SAMPLE_W-1:0], 1'b0});
			end
			ftma_pkg::ST_DIV_RATE: begin
				div_step = 1'b1;
			end
			ftma_pkg::ST_DONE: begin
				out_ld = !out_valid_q || !out_stall;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ftma_pkg::ST_IDLE;
			time_scale_q <= ftma_pkg::TIME_SCALE_RST;
			sum_q        <= '0;
			fill_q       <= '0;
			wr_ptr_q     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_wr_en) time_scale_q <= cfg_wr_data;
			if (upd_en) begin
				sum_q  <= sum_nxt;
				fill_q <= fill_nxt;
				if (wr_ptr_q == PTR_W'(ftma_pkg::WINDOW - 1)) wr_ptr_q <= '0;
				else wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (out_ld) out_valid_q <= 1'b1;
			else if (out_xfer) out_valid_q <= 1'b0;
		end
	end

	// sample memory: read of the slot to be evicted on the input transfer
	always_ff @(posedge clk) begin
		if (in_xfer) rd_data_q <= win_mem_q[wr_ptr_q];
		if (upd_en) win_mem_q[wr_ptr_q] <= x_q;
	end

	// payload and shared divider
	always_ff @(posedge clk) begin
		if (in_xfer) x_q <= frame_time;
		if (upd_en) begin
			if (|prod[PROD_W-1:SAMPLE_W+FRAC_W]) scaled_q <= '1;
			else scaled_q <= prod[SAMPLE_W+FRAC_W-1:FRAC_W];
		end
		if (mean_ld) mean_q <= div_quo_q[SAMPLE_W-1:0];
		if (div_load) begin
			div_rem_q <= '0;
			div_quo_q <= div_num;
			div_den_q <= div_den;
			div_cnt_q <= DCNT_W'(DIV_W - 1);
		end else if (div_step) begin
			div_rem_q <= trial_ge ? trial_diff[DIV_W-1:0] : trial[DIV_W-1:0];
			div_quo_q <= {div_quo_q[DIV_W-2:0], trial_ge};
			div_cnt_q <= div_cnt_q - DCNT_W'(1);
		end
		if (out_ld) begin
			out_scaled_q <= scaled_q;
			out_mean_q   <= mean_q;
			out_rate_q   <= (mean_q == '0) ? '0 : div_quo_q[RATE_W-1:0];
			out_full_q   <= win_full;
		end
	end

	assign out_valid    = out_valid_q;
	assign scaled_delta = out_scaled_q;
	assign mean_delta   = out_mean_q;
	assign mean_rate    = out_rate_q;
	assign window_full  = out_full_q;

`ifndef ASSERT_OFF
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(ftma_pkg::WINDOW))
		else $error("fill count beyond window");

	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_ptr_q <= PTR_W'(ftma_pkg::WINDOW - 1))
		else $error("write pointer beyond window");

	a_full_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		win_full |=> win_full)
		else $error("window left the full state");

	a_xfer_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == ftma_pkg::ST_UPDATE) && in_stall)
		else $error("input transfer did not start an update");
`endif

endmodule
